// ===== rtl/lnrast_pkg.sv =====
// ----------------------------------------------------------------------------
// lnrast_pkg
// Types and constants shared by the line rasterizer: request and response
// transfer layouts, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package lnrast_pkg;

   localparam int COORD_BITS = 12;
   localparam int WIDTH_BITS = 13;
   localparam int ADDR_BITS  = 32;
   localparam int COLOR_BITS = 32;
   localparam int CSR_BITS   = 32;
   localparam int CSR_INDEX_BITS = 1;

   // decision variable and its two increments
   localparam int ERR_BITS   = COORD_BITS + 4;
   localparam int STEPM_BITS = COORD_BITS + 2;
   localparam int STEPB_BITS = COORD_BITS + 3;

   localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = WIDTH_BITS'(800);

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_BASE = 1'b0,
      CSR_LINE_WIDTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                  kind;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
      logic [COLOR_BITS-1:0] color;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  pixel_address;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  last;
   } rsp_type;

endpackage

// ===== rtl/line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// line_rasterizer_core
// Integer Bresenham line engine: a start transfer loads two endpoints and a
// color and emits the first pixel; each step transfer emits the next pixel
// with its frame buffer byte address.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              content
//   req_     in         req_valid / req_stall  start or step command
//   rsp_     out        rsp_valid / rsp_stall  pixel address, x, y, color, last
//   csr_     in         csr_write_enable       frame_base, line_width writes
//
// One transfer is taken every cycle unless req_stall is high; each pixel goes
// from the pixel stage through the address multiply-add to the output register.
// The rate is set by the line state loop: major/minor/error update together.
// Reset is synchronous: it drops the line in progress and both pipeline stages,
// and restores frame_base to 0 and line_width to 800.
// req_stall rises only when both the pixel stage and the output register are
// full and rsp_stall is high; a step with no line in progress gives no pixel.
// ----------------------------------------------------------------------------
module line_rasterizer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lnrast_pkg::req_type                   req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lnrast_pkg::rsp_type                   rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [lnrast_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lnrast_pkg::CSR_BITS-1:0]       csr_write_data
);

   localparam int C    = lnrast_pkg::COORD_BITS;
   localparam int E    = lnrast_pkg::ERR_BITS;
   localparam int SM   = lnrast_pkg::STEPM_BITS;
   localparam int SB   = lnrast_pkg::STEPB_BITS;
   localparam int W    = lnrast_pkg::WIDTH_BITS;
   localparam int A    = lnrast_pkg::ADDR_BITS;
   localparam int CB   = lnrast_pkg::COLOR_BITS;
   localparam int PROD = C + W;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [A-1:0] frame_base_ff, frame_base_in;
   logic [W-1:0] line_width_ff, line_width_in;

   always_comb begin
      frame_base_in = frame_base_ff;
      line_width_in = line_width_ff;
      if (csr_write_enable) begin
         unique case (lnrast_pkg::csr_index_type'(csr_index))
            lnrast_pkg::CSR_FRAME_BASE: frame_base_in = csr_write_data[A-1:0];
            lnrast_pkg::CSR_LINE_WIDTH: line_width_in = csr_write_data[W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= '0;
         line_width_ff <= lnrast_pkg::LINE_WIDTH_RESET;
      end else begin
         frame_base_ff <= frame_base_in;
         line_width_ff <= line_width_in;
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline handshake: pixel stage (a_) feeds the output register
   // ------------------------------------------------------------------------
   logic a_valid_ff, a_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, a_free, req_accept;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign a_free     = !a_valid_ff || out_free;
   assign req_stall  = !a_free;
   assign req_accept = req_valid && !req_stall;

   // ------------------------------------------------------------------------
   // Line setup from a start transfer
   // ------------------------------------------------------------------------
   logic [C:0]   dx, dy;
   logic [C-1:0] adx, ady, amaj, amin;
   logic         setup_xmaj, setup_swap, dx_pos, dy_pos, dx_neg, dy_neg;
   logic [C-1:0] setup_x, setup_y, setup_stop;
   logic [E-1:0] setup_err;
   logic [SM-1:0] setup_stepm;
   logic [SB-1:0] setup_stepb;

   always_comb begin
      dx  = {1'b0, req_data.x_end} - {1'b0, req_data.x_start};
      dy  = {1'b0, req_data.y_end} - {1'b0, req_data.y_start};
      adx = dx[C] ? C'(~dx + 1'b1) : dx[C-1:0];
      ady = dy[C] ? C'(~dy + 1'b1) : dy[C-1:0];
      dx_neg = dx[C];
      dy_neg = dy[C];
      dx_pos = !dx[C] && (dx != '0);
      dy_pos = !dy[C] && (dy != '0);

      setup_xmaj = adx > ady;
      setup_swap = setup_xmaj ? dx_neg : dy_neg;
      amaj       = setup_xmaj ? adx : ady;
      amin       = setup_xmaj ? ady : adx;

      // order the endpoints so the major coordinate rises
      setup_x = setup_swap ? req_data.x_end : req_data.x_start;
      setup_y = setup_swap ? req_data.y_end : req_data.y_start;
      if (setup_xmaj) begin
         setup_stop = setup_swap ? req_data.x_start : req_data.x_end;
      end else begin
         setup_stop = setup_swap ? req_data.y_start : req_data.y_end;
      end

      setup_err   = {3'b000, amin, 1'b0} - {4'b0000, amaj};
      setup_stepm = {1'b0, amin, 1'b0};
      setup_stepb = {2'b00, amin, 1'b0} - {2'b00, amaj, 1'b0};
   end

   // ------------------------------------------------------------------------
   // Line state and per-pixel Bresenham step
   // ------------------------------------------------------------------------
   logic          busy_ff, busy_in;
   logic [C-1:0]  cur_x_ff, cur_y_ff, stop_ff;
   logic [E-1:0]  err_ff;
   logic [SM-1:0] stepm_ff;
   logic [SB-1:0] stepb_ff;
   logic          xmaj_ff, up_ff;
   logic [CB-1:0] color_ff;

   logic          is_start, produce;
   logic [C-1:0]  c_x, c_y, c_stop, c_major, c_minor, n_major, n_minor;
   logic [E-1:0]  c_err, n_err;
   logic [SM-1:0] c_stepm;
   logic [SB-1:0] c_stepb;
   logic          c_xmaj, c_up, c_fin;
   logic [CB-1:0] c_color;
   logic [C-1:0]  n_x, n_y;

   assign is_start = (lnrast_pkg::kind_type'(req_data.kind) == lnrast_pkg::KIND_START);
   assign produce  = is_start || busy_ff;

   always_comb begin
      // take the fresh setup on start, the stored line otherwise
      c_x     = is_start ? setup_x     : cur_x_ff;
      c_y     = is_start ? setup_y     : cur_y_ff;
      c_stop  = is_start ? setup_stop  : stop_ff;
      c_err   = is_start ? setup_err   : err_ff;
      c_stepm = is_start ? setup_stepm : stepm_ff;
      c_stepb = is_start ? setup_stepb : stepb_ff;
      c_xmaj  = is_start ? setup_xmaj  : xmaj_ff;
      c_up    = is_start ? ((dx_pos && dy_pos) || (dx_neg && dy_neg)) : up_ff;
      c_color = is_start ? req_data.color : color_ff;

      c_major = c_xmaj ? c_x : c_y;
      c_minor = c_xmaj ? c_y : c_x;
      c_fin   = (c_major == c_stop);
      n_major = c_major + 1'b1;

      // negative error: advance major only; else step the minor axis too
      if (c_err[E-1]) begin
         n_minor = c_minor;
         n_err   = c_err + {2'b00, c_stepm};
      end else begin
         n_minor = c_up ? c_minor + 1'b1 : c_minor - 1'b1;
         n_err   = c_err + {c_stepb[SB-1], c_stepb};
      end

      n_x = c_xmaj ? n_major : n_minor;
      n_y = c_xmaj ? n_minor : n_major;
      busy_in = busy_ff;
      if (req_accept && produce) begin
         busy_in = !c_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && produce) begin
         cur_x_ff <= n_x;
         cur_y_ff <= n_y;
         stop_ff  <= c_stop;
         err_ff   <= n_err;
         stepm_ff <= c_stepm;
         stepb_ff <= c_stepb;
         xmaj_ff  <= c_xmaj;
         up_ff    <= c_up;
         color_ff <= c_color;
      end
   end

   // ------------------------------------------------------------------------
   // Pixel stage: hold the emitted pixel until the output register frees
   // ------------------------------------------------------------------------
   logic [C-1:0]  a_x_ff, a_y_ff;
   logic [CB-1:0] a_color_ff;
   logic          a_last_ff;

   assign a_valid_in = a_free ? (req_accept && produce) : a_valid_ff;

   always_ff @(posedge clock) begin
      if (a_free) begin
         a_x_ff     <= c_x;
         a_y_ff     <= c_y;
         a_color_ff <= c_color;
         a_last_ff  <= c_fin;
      end
   end

   // ------------------------------------------------------------------------
   // Address stage: base + 4*(x + y*width), wrapping at the address width
   // ------------------------------------------------------------------------
   logic [PROD-1:0] row_offset;
   logic [A-1:0]    linear, address;
   lnrast_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      row_offset = {{W{1'b0}}, a_y_ff} * {{C{1'b0}}, line_width_ff};
      linear     = A'(row_offset) + A'(a_x_ff);
      address    = frame_base_ff + {linear[A-3:0], 2'b00};

      rsp_data_in               = rsp_data_ff;
      if (out_free) begin
         rsp_data_in.pixel_address = address;
         rsp_data_in.pixel_x       = a_x_ff;
         rsp_data_in.pixel_y       = a_y_ff;
         rsp_data_in.pixel_color   = a_color_ff;
         rsp_data_in.last          = a_last_ff;
      end
   end

   assign out_valid_in = out_free ? a_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // back-pressure only when both stages are occupied
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && out_valid_ff))
      else $error("req_stall raised with a free pipeline slot");

   // a step with no line in progress must not create a pixel
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_start && !busy_ff) |=> !a_valid_ff)
      else $error("step while idle produced a pixel");

   // the final pixel of a line ends the line
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && produce && c_fin) |=> !busy_ff)
      else $error("line still busy after its final pixel");

   // a line only ends on an accepted transfer
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(req_accept))
      else $error("line ended without a transfer");

endmodule
